>>> rtl/rfr_pkg.sv
`timescale 1ns / 1ps
// rfr_pkg: shared widths, command and status codes, flag bit positions
// and the region entry type of the region fault resolver
// no dependencies

package rfr_pkg;

    // default table shape
    localparam int DEF_REGIONS  = 16;
    localparam int DEF_CONTEXTS = 8;

    // field widths
    localparam int CMD_W   = 2;
    localparam int CTXID_W = 3;
    localparam int VA_W    = 48;
    localparam int SIZE_W  = 49;
    localparam int PA_W    = 52;
    localparam int FLAG_W  = 4;
    localparam int FCODE_W = 5;
    localparam int STAT_W  = 3;

    // page geometry
    localparam int PAGE_BITS = 12;

    // commands
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FAULT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADFLAGS = 3'd2;
    localparam logic [STAT_W-1:0] ST_PRESENT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOREGION = 3'd4;
    localparam logic [STAT_W-1:0] ST_DENIED   = 3'd5;

    // region flag bits
    localparam int RF_WRITE_BIT = 1;
    localparam int RF_USER_BIT  = 2;
    localparam int RF_EXEC_BIT  = 3;

    // fault code bits
    localparam int FC_PRESENT_BIT = 0;
    localparam int FC_WRITE_BIT   = 1;
    localparam int FC_USER_BIT    = 2;
    localparam int FC_INSTR_BIT   = 4;

    // one stored region
    typedef struct packed {
        logic [VA_W-1:0]   base;
        logic [SIZE_W-1:0] size;
        logic [PA_W-1:0]   phys;
        logic [FLAG_W-1:0] flags;
    } entry_t;

endpackage

>>> rtl/rfr_req_if.sv
`timescale 1ns / 1ps
// rfr_req_if: request channel of the region fault resolver
// depends on rfr_pkg

interface rfr_req_if
    import rfr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [CTXID_W-1:0]  context_req;
    logic [VA_W-1:0]     address;
    logic [SIZE_W-1:0]   region_size;
    logic [PA_W-1:0]     backing_base;
    logic [FLAG_W-1:0]   region_flags;
    logic [FCODE_W-1:0]  fault_code;

    modport source (
        output valid, command, context_req, address, region_size,
               backing_base, region_flags, fault_code,
        input  ready
    );

    modport sink (
        input  valid, command, context_req, address, region_size,
               backing_base, region_flags, fault_code,
        output ready
    );
endinterface

>>> rtl/rfr_rsp_if.sv
`timescale 1ns / 1ps
// rfr_rsp_if: result channel of the region fault resolver
// depends on rfr_pkg

interface rfr_rsp_if
    import rfr_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [VA_W-1:0]     mapped_page;
    logic [PA_W-1:0]     backing_page;
    logic [FLAG_W-1:0]   page_flags;

    modport source (
        output valid, status, mapped_page, backing_page, page_flags,
        input  ready
    );

    modport sink (
        input  valid, status, mapped_page, backing_page, page_flags,
        output ready
    );
endinterface

>>> rtl/region_fault_resolver.sv
`timescale 1ns / 1ps
// region_fault_resolver: per-context region table with a sequential fault lookup
// depends on rfr_pkg, rfr_req_if and rfr_rsp_if

// The block takes one request word at a time and answers each with exactly one
// result word. Add, clear and unused commands finish in the cycle they are
// accepted; the result goes to the output register once it is free or drained. A fault
// walks the slot's regions in insertion order through a single table read port
// and one shared containment compare, one region per cycle with the read
// pipelined against the compare, and stops at the first match or after the
// slot's last region (at most REGIONS regions). The next request is taken as
// soon as the sequencer is idle, even if the previous result has not yet been
// taken. The region table holds no reset value; only entries below a slot's
// region count are ever read.

module region_fault_resolver
    import rfr_pkg::*;
#(
    parameter int REGIONS  = DEF_REGIONS,
    parameter int CONTEXTS = DEF_CONTEXTS
)
(
    input  logic      clk,
    input  logic      rst_n,
    rfr_req_if.sink   req,
    rfr_rsp_if.source rsp
);

    localparam int DEPTH = CONTEXTS * REGIONS;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CTX_W = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int CNT_W = $clog2(REGIONS + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_PHYS  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // region table and read stage
    entry_t entry_mem [DEPTH];
    entry_t rd_data_reg;

    // control state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg [CONTEXTS];
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic             rd_valid_reg, rd_valid_next;
    logic             rd_last_reg, rd_last_next;
    logic             out_valid_reg, out_valid_next;

    // latched request and working results
    logic [VA_W-1:0]    addr_reg, addr_next;
    logic [FCODE_W-1:0] fcode_reg, fcode_next;
    logic [PA_W-1:0]    diff_reg, diff_next;
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [VA_W-1:0]    res_page_reg, res_page_next;
    logic [PA_W-1:0]    res_phys_reg, res_phys_next;
    logic [FLAG_W-1:0]  res_flags_reg, res_flags_next;

    // output register
    logic [STAT_W-1:0]  out_status_reg;
    logic [VA_W-1:0]    out_page_reg;
    logic [PA_W-1:0]    out_phys_reg;
    logic [FLAG_W-1:0]  out_flags_reg;
    logic               out_load;

    // request decode
    logic             accept;
    logic             slot_valid;
    logic [CTX_W-1:0] ctx_idx;
    logic [CNT_W-1:0] cur_count;
    logic [IDX_W-1:0] slot_base;
    logic             add_full;
    logic             add_badflags;

    // table access
    logic             mem_we;
    logic [IDX_W-1:0] wr_idx;
    entry_t           wr_entry;
    logic             rd_en;

    // region count update
    logic             count_we;
    logic [CNT_W-1:0] count_wdata;

    // shared containment compare
    logic [VA_W+1:0]  span_end;
    logic             contained;
    logic             hit_now;
    logic             denied;
    logic [VA_W-1:0]  page_addr;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && (state_reg == S_IDLE);

    assign slot_valid   = (32'(req.context_req) < CONTEXTS);
    assign ctx_idx      = CTX_W'(req.context_req);
    assign cur_count    = count_reg[ctx_idx];
    assign slot_base    = IDX_W'(32'(ctx_idx) * REGIONS);
    assign add_full     = !slot_valid || (32'(cur_count) >= REGIONS);
    assign add_badflags = req.region_flags[RF_USER_BIT] && req.region_flags[RF_WRITE_BIT]
                          && req.region_flags[RF_EXEC_BIT];

    assign wr_idx   = slot_base + IDX_W'(cur_count);
    assign wr_entry = '{base: req.address, size: req.region_size,
                        phys: req.backing_base, flags: req.region_flags};

    // containment of the latched address in the entry just read, no wrap
    assign span_end  = (VA_W+2)'(rd_data_reg.base) + (VA_W+2)'(rd_data_reg.size);
    assign contained = (addr_reg >= rd_data_reg.base) && ((VA_W+2)'(addr_reg) < span_end);
    assign hit_now   = rd_valid_reg && contained;

    // access rights of the matching region
    assign denied = (fcode_reg[FC_USER_BIT]  && !rd_data_reg.flags[RF_USER_BIT])  ||
                    (fcode_reg[FC_WRITE_BIT] && !rd_data_reg.flags[RF_WRITE_BIT]) ||
                    (fcode_reg[FC_INSTR_BIT] && !rd_data_reg.flags[RF_EXEC_BIT]);
    assign page_addr = {addr_reg[VA_W-1:PAGE_BITS], {PAGE_BITS{1'b0}}};

    assign rd_en = (state_reg == S_SCAN) && (left_reg != '0) && !hit_now;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        left_next       = left_reg;
        rd_valid_next   = rd_valid_reg;
        rd_last_next    = rd_last_reg;
        out_valid_next  = out_valid_reg;
        addr_next       = addr_reg;
        fcode_next      = fcode_reg;
        diff_next       = diff_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_phys_next   = res_phys_reg;
        res_flags_next  = res_flags_reg;
        mem_we          = 1'b0;
        count_we        = 1'b0;
        count_wdata     = '0;
        out_load        = 1'b0;

        // output register drains independently
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    addr_next       = req.address;
                    fcode_next      = req.fault_code;
                    res_status_next = ST_OK;
                    res_page_next   = '0;
                    res_phys_next   = '0;
                    res_flags_next  = '0;
                    state_next      = S_DONE;
                    case (req.command)
                        CMD_ADD:
                        begin
                            if (add_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (add_badflags)
                            begin
                                res_status_next = ST_BADFLAGS;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                count_we    = 1'b1;
                                count_wdata = cur_count + CNT_W'(1);
                            end
                        end
                        CMD_FAULT:
                        begin
                            if (req.fault_code[FC_PRESENT_BIT])
                            begin
                                res_status_next = ST_PRESENT;
                            end
                            else if (!slot_valid || (cur_count == '0))
                            begin
                                res_status_next = ST_NOREGION;
                            end
                            else
                            begin
                                scan_idx_next = slot_base;
                                left_next     = cur_count;
                                rd_valid_next = 1'b0;
                                rd_last_next  = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            if (slot_valid)
                            begin
                                count_we    = 1'b1;
                                count_wdata = '0;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // issue the next read while comparing the previous one
                if (rd_en)
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    left_next     = left_reg - CNT_W'(1);
                    rd_valid_next = 1'b1;
                    rd_last_next  = (left_reg == CNT_W'(1));
                end
                else
                begin
                    rd_valid_next = 1'b0;
                end
                if (hit_now)
                begin
                    rd_valid_next = 1'b0;
                    state_next    = S_CHECK;
                end
                else if (rd_valid_reg && rd_last_reg)
                begin
                    rd_valid_next   = 1'b0;
                    res_status_next = ST_NOREGION;
                    state_next      = S_DONE;
                end
            end
            S_CHECK:
            begin
                if (denied)
                begin
                    res_status_next = ST_DENIED;
                    state_next      = S_DONE;
                end
                else
                begin
                    diff_next      = PA_W'(page_addr) - PA_W'(rd_data_reg.base);
                    res_page_next  = page_addr;
                    res_flags_next = rd_data_reg.flags;
                    state_next     = S_PHYS;
                end
            end
            S_PHYS:
            begin
                res_phys_next   = rd_data_reg.phys + diff_reg;
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_idx_reg  <= '0;
            left_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CONTEXTS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            left_reg      <= left_next;
            rd_valid_reg  <= rd_valid_next;
            rd_last_reg   <= rd_last_next;
            out_valid_reg <= out_valid_next;
            if (count_we)
            begin
                count_reg[ctx_idx] <= count_wdata;
            end
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        fcode_reg      <= fcode_next;
        diff_reg       <= diff_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_phys_reg   <= res_phys_next;
        res_flags_reg  <= res_flags_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_page_reg   <= res_page_reg;
            out_phys_reg   <= res_phys_reg;
            out_flags_reg  <= res_flags_reg;
        end
    end

    // region table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[wr_idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[scan_idx_reg];
        end
    end

    // result word
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.mapped_page  = out_page_reg;
    assign rsp.backing_page = out_phys_reg;
    assign rsp.page_flags   = out_flags_reg;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench of the region fault resolver, with directed,
// table-full, streaming, backpressure and random session tests
// depends on rfr_pkg, rfr_req_if, rfr_rsp_if and region_fault_resolver

module tb_top;
    import rfr_pkg::*;

    localparam int N_REGIONS   = DEF_REGIONS;
    localparam int N_CONTEXTS  = DEF_CONTEXTS;
    localparam int WORD_TARGET = 950;
    localparam int TAIL_CYCLES = 60;
    localparam int MAX_REPORTS = 50;
    localparam int HOLD_CYCLES = 150;

    // command code the block does not define
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    // region flag masks
    localparam logic [FLAG_W-1:0] RF_RD  = 4'b0001;
    localparam logic [FLAG_W-1:0] RF_WR  = FLAG_W'(1 << RF_WRITE_BIT);
    localparam logic [FLAG_W-1:0] RF_USR = FLAG_W'(1 << RF_USER_BIT);
    localparam logic [FLAG_W-1:0] RF_EX  = FLAG_W'(1 << RF_EXEC_BIT);

    // fault code masks, bit 3 carries no meaning
    localparam int                 FC_SPARE_BIT = 3;
    localparam logic [FCODE_W-1:0] FC_PRES  = FCODE_W'(1 << FC_PRESENT_BIT);
    localparam logic [FCODE_W-1:0] FC_WR    = FCODE_W'(1 << FC_WRITE_BIT);
    localparam logic [FCODE_W-1:0] FC_USR   = FCODE_W'(1 << FC_USER_BIT);
    localparam logic [FCODE_W-1:0] FC_INS   = FCODE_W'(1 << FC_INSTR_BIT);
    localparam logic [FCODE_W-1:0] FC_SPARE = FCODE_W'(1 << FC_SPARE_BIT);

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [CTXID_W-1:0] slot;
        logic [VA_W-1:0]    address;
        logic [SIZE_W-1:0]  region_size;
        logic [PA_W-1:0]    backing_base;
        logic [FLAG_W-1:0]  region_flags;
        logic [FCODE_W-1:0] fault_code;
    } request_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VA_W-1:0]   mapped_page;
        logic [PA_W-1:0]   backing_page;
        logic [FLAG_W-1:0] page_flags;
    } result_t;

    logic clk = 1'b0;
    logic rst_n;

    rfr_req_if req_ch();
    rfr_rsp_if rsp_ch();

    region_fault_resolver #(
        .REGIONS  (N_REGIONS),
        .CONTEXTS (N_CONTEXTS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // shadow region table
    logic [VA_W-1:0]   tbl_base  [N_CONTEXTS][N_REGIONS];
    logic [SIZE_W-1:0] tbl_size  [N_CONTEXTS][N_REGIONS];
    logic [PA_W-1:0]   tbl_phys  [N_CONTEXTS][N_REGIONS];
    logic [FLAG_W-1:0] tbl_flags [N_CONTEXTS][N_REGIONS];
    int                tbl_count [N_CONTEXTS];

    result_t pending_results [$];

    int fail_count   = 0;
    int words_sent   = 0;
    int burst_left   = 0;
    int hold_off_len = 0;
    bit tx_gaps_on   = 1'b1;
    bit rx_stall_on  = 1'b1;

    // clock, 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #4_000_000;
        $display("[region_fault_resolver] ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // expected result of one accepted word, shadow table updated in order
    task automatic resolve_word(input request_t w);
        result_t           r;
        logic [SIZE_W:0]   lim;
        logic [VA_W-1:0]   page;
        logic [FLAG_W-1:0] f;
        bit                hit;
        int                s;
        r   = '0;
        r.status = ST_OK;
        hit = 1'b0;
        s   = int'(w.slot);
        case (w.command)
            CMD_ADD:
            begin
                if (s >= N_CONTEXTS || tbl_count[s] >= N_REGIONS)
                    r.status = ST_FULL;
                else if (w.region_flags[RF_USER_BIT] && w.region_flags[RF_WRITE_BIT] &&
                         w.region_flags[RF_EXEC_BIT])
                    r.status = ST_BADFLAGS;
                else
                begin
                    tbl_base[s][tbl_count[s]]  = w.address;
                    tbl_size[s][tbl_count[s]]  = w.region_size;
                    tbl_phys[s][tbl_count[s]]  = w.backing_base;
                    tbl_flags[s][tbl_count[s]] = w.region_flags;
                    tbl_count[s]++;
                end
            end
            CMD_FAULT:
            begin
                if (w.fault_code[FC_PRESENT_BIT])
                    r.status = ST_PRESENT;
                else
                begin
                    r.status = ST_NOREGION;
                    // first region in insertion order that holds the address
                    for (int i = 0; s < N_CONTEXTS && i < tbl_count[s] && !hit; i++)
                    begin
                        lim = (SIZE_W+1)'(tbl_base[s][i]) + (SIZE_W+1)'(tbl_size[s][i]);
                        if ((SIZE_W+1)'(w.address) >= (SIZE_W+1)'(tbl_base[s][i]) &&
                            (SIZE_W+1)'(w.address) < lim)
                        begin
                            hit = 1'b1;
                            f   = tbl_flags[s][i];
                            if ((w.fault_code[FC_USER_BIT] && !f[RF_USER_BIT]) ||
                                (w.fault_code[FC_WRITE_BIT] && !f[RF_WRITE_BIT]) ||
                                (w.fault_code[FC_INSTR_BIT] && !f[RF_EXEC_BIT]))
                                r.status = ST_DENIED;
                            else
                            begin
                                page           = {w.address[VA_W-1:PAGE_BITS],
                                                  {PAGE_BITS{1'b0}}};
                                r.status       = ST_OK;
                                r.mapped_page  = page;
                                r.backing_page = tbl_phys[s][i] +
                                                 (PA_W'(page) - PA_W'(tbl_base[s][i]));
                                r.page_flags   = f;
                            end
                        end
                    end
                end
            end
            CMD_CLEAR:
            begin
                if (s < N_CONTEXTS)
                    tbl_count[s] = 0;
            end
            default:
            begin
            end
        endcase
        pending_results.push_back(r);
    endtask

    // result checker
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
                report_mismatch($sformatf("result word with none expected, status %0d",
                                          rsp_ch.status));
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp_ch.status, want.status));
                if (rsp_ch.mapped_page !== want.mapped_page)
                    report_mismatch($sformatf("mapped_page 0x%0h, expected 0x%0h",
                                              rsp_ch.mapped_page, want.mapped_page));
                if (rsp_ch.backing_page !== want.backing_page)
                    report_mismatch($sformatf("backing_page 0x%0h, expected 0x%0h",
                                              rsp_ch.backing_page, want.backing_page));
                if (rsp_ch.page_flags !== want.page_flags)
                    report_mismatch($sformatf("page_flags 0x%0h, expected 0x%0h",
                                              rsp_ch.page_flags, want.page_flags));
            end
        end
    end

    // receiver: long hold-off on request, else always ready or alternating ready and stall runs
    initial
    begin : rx_pattern
        bit rx_high;
        int rx_run;
        rx_high      = 1'b0;
        rx_run       = 0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_len > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_off_len--;
            end
            else if (!rx_stall_on)
                rsp_ch.ready <= 1'b1;
            else
            begin
                if (rx_run == 0)
                begin
                    rx_high = !rx_high;
                    rx_run  = rx_high ? $urandom_range(1, 12) : $urandom_range(1, 5);
                end
                rx_run--;
                rsp_ch.ready <= rx_high;
            end
        end
    end

    function automatic request_t make_word(input logic [CMD_W-1:0] cmd,
                                           input logic [CTXID_W-1:0] slot,
                                           input logic [VA_W-1:0] addr,
                                           input logic [SIZE_W-1:0] size,
                                           input logic [PA_W-1:0] phys,
                                           input logic [FLAG_W-1:0] flags,
                                           input logic [FCODE_W-1:0] fcode);
        request_t w;
        w.command      = cmd;
        w.slot         = slot;
        w.address      = addr;
        w.region_size  = size;
        w.backing_base = phys;
        w.region_flags = flags;
        w.fault_code   = fcode;
        return w;
    endfunction

    function automatic logic [VA_W-1:0] rand_va();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[VA_W-1:0];
    endfunction

    function automatic logic [PA_W-1:0] rand_pa();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[PA_W-1:0];
    endfunction

    // mostly small regions, now and then empty, huge or the full span
    function automatic logic [SIZE_W-1:0] rand_size();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return SIZE_W'(1) << VA_W;
            2:       return SIZE_W'(r[VA_W-1:0]);
            3:       return SIZE_W'($urandom_range(1, 4095));
            default: return SIZE_W'($urandom_range(1, 64)) << PAGE_BITS;
        endcase
    endfunction

    // non-present faults most of the time
    function automatic logic [FCODE_W-1:0] rand_fault_code();
        logic [31:0]        r;
        logic [FCODE_W-1:0] fc;
        r  = $urandom;
        fc = r[FCODE_W-1:0];
        if ($urandom_range(0, 9) != 0)
            fc[FC_PRESENT_BIT] = 1'b0;
        return fc;
    endfunction

    // send one word: bursts with random gaps, waits for the handshake
    task automatic send_word(input request_t w);
        @(negedge clk);
        if (tx_gaps_on && burst_left <= 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= w.command;
        req_ch.context_req  <= w.slot;
        req_ch.address      <= w.address;
        req_ch.region_size  <= w.region_size;
        req_ch.backing_base <= w.backing_base;
        req_ch.region_flags <= w.region_flags;
        req_ch.fault_code   <= w.fault_code;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        resolve_word(w);
        words_sent++;
        burst_left--;
    endtask

    task automatic idle_channel();
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    // fault aimed inside a stored region, at its edges, or near the window
    task automatic send_fault(input logic [CTXID_W-1:0] slot, input logic [VA_W-1:0] window);
        logic [VA_W-1:0] target;
        logic [63:0]     off;
        int              pick;
        int              k;
        pick = $urandom_range(0, 99);
        k    = (tbl_count[slot] > 0) ? $urandom_range(0, tbl_count[slot] - 1) : 0;
        if (tbl_count[slot] == 0 || pick >= 80)
            target = window + VA_W'($urandom_range(0, 'h50000));
        else if (pick < 60)
        begin
            off = {$urandom, $urandom};
            off = (tbl_size[slot][k] == '0) ? 64'd0 : off % 64'(tbl_size[slot][k]);
            target = tbl_base[slot][k] + off[VA_W-1:0];
        end
        else
        begin
            case (pick % 3)
                0:       target = tbl_base[slot][k] - 1'b1;
                1:       target = tbl_base[slot][k] + tbl_size[slot][k][VA_W-1:0] - 1'b1;
                default: target = tbl_base[slot][k] + tbl_size[slot][k][VA_W-1:0];
            endcase
        end
        send_word(make_word(CMD_FAULT, slot, target, rand_size(), rand_pa(),
                            FLAG_W'($urandom), rand_fault_code()));
    endtask

    // one session: maybe clear, a few adds near a window, then faults
    task automatic run_session();
        logic [CTXID_W-1:0] slot;
        logic [VA_W-1:0]    window;
        slot   = CTXID_W'($urandom_range(0, N_CONTEXTS - 1));
        window = rand_va();
        if ($urandom_range(0, 3) == 0)
            send_word(make_word(CMD_CLEAR, slot, rand_va(), rand_size(), rand_pa(),
                                FLAG_W'($urandom), FCODE_W'($urandom)));
        repeat ($urandom_range(1, 6))
            send_word(make_word(CMD_ADD, slot, window + VA_W'($urandom_range(0, 'h40000)),
                                rand_size(), rand_pa(), FLAG_W'($urandom),
                                FCODE_W'($urandom)));
        repeat ($urandom_range(3, 12))
            send_fault(slot, window);
    endtask

    // empty table, present faults, unused command, clear of an empty slot
    task automatic test_empty_table();
        send_word(make_word(CMD_FAULT, 3'd0, '0, '0, '0, '0, '0));
        send_word(make_word(CMD_FAULT, 3'd0, '1, '0, '0, '0, FC_PRES));
        send_word(make_word(CMD_SPARE, 3'd7, '1, SIZE_W'(1) << VA_W, '1, '1, '1));
        send_word(make_word(CMD_CLEAR, 3'd5, '0, '0, '0, '0, '0));
    endtask

    // field extremes, bad flags, empty region, top of the address space,
    // page below an unaligned base, first match wins, every denial
    task automatic test_region_extremes();
        send_word(make_word(CMD_ADD, 3'd1, '0, '0, '1, RF_USR | RF_WR | RF_EX, '0));
        send_word(make_word(CMD_ADD, 3'd1, '0, '0, '1, RF_RD, '0));
        send_word(make_word(CMD_FAULT, 3'd1, '0, '0, '0, '0, '0));
        send_word(make_word(CMD_ADD, 3'd1, 48'hFFFF_FFFF_F000, SIZE_W'(1) << VA_W, '0,
                            RF_RD | RF_WR | RF_USR, '0));
        send_word(make_word(CMD_FAULT, 3'd1, '1, '0, '0, '0, FC_USR | FC_WR));
        send_word(make_word(CMD_FAULT, 3'd1, '1, '0, '0, '0, FC_INS));
        send_word(make_word(CMD_ADD, 3'd1, 48'h1234, 49'h2000, '0,
                            RF_RD | RF_USR | RF_EX, '0));
        send_word(make_word(CMD_FAULT, 3'd1, 48'h1300, '0, '0, '0, FC_USR | FC_SPARE));
        send_word(make_word(CMD_FAULT, 3'd1, 48'h1300, '0, '0, '0, FC_WR));
        send_word(make_word(CMD_FAULT, 3'd1, 48'h3234, '0, '0, '0, '0));
        send_word(make_word(CMD_FAULT, 3'd1, 48'h1233, '0, '0, '0, '0));
        send_word(make_word(CMD_ADD, 3'd1, 48'h1000, 49'h10000, '1,
                            RF_RD | RF_WR | RF_EX, '0));
        send_word(make_word(CMD_FAULT, 3'd1, 48'h1300, '0, '0, '0, FC_INS));
        send_word(make_word(CMD_FAULT, 3'd1, 48'h1300, '0, '0, '0, FC_WR));
        send_word(make_word(CMD_FAULT, 3'd1, 48'h5000, '0, '0, '0, FC_WR | FC_INS));
        send_word(make_word(CMD_FAULT, 3'd1, 48'h5000, '0, '0, '0, FC_USR));
        send_word(make_word(CMD_CLEAR, 3'd1, '0, '0, '0, '0, '0));
        send_word(make_word(CMD_FAULT, 3'd1, 48'h5000, '0, '0, '0, '0));
        send_word(make_word(CMD_ADD, 3'd1, '1, 49'd1, rand_pa(), '1, '0));
        send_word(make_word(CMD_ADD, 3'd1, '1, 49'd1, rand_pa(), '0, '0));
        send_word(make_word(CMD_FAULT, 3'd1, '1, '0, '0, '0, '0));
    endtask

    // fill a slot, then full answers ahead of bad flags, lookups over a full slot
    task automatic test_table_full();
        logic [CTXID_W-1:0] slot;
        logic [VA_W-1:0]    window;
        logic [FLAG_W-1:0]  fl;
        repeat (2)
        begin
            slot   = CTXID_W'($urandom_range(0, N_CONTEXTS - 1));
            window = rand_va();
            send_word(make_word(CMD_CLEAR, slot, '0, '0, '0, '0, '0));
            repeat (N_REGIONS)
            begin
                fl = FLAG_W'($urandom);
                if (fl[RF_USER_BIT] && fl[RF_WRITE_BIT] && fl[RF_EXEC_BIT])
                    fl[RF_USER_BIT] = 1'b0;
                send_word(make_word(CMD_ADD, slot, window + VA_W'($urandom_range(0, 'h40000)),
                                    rand_size(), rand_pa(), fl, '0));
            end
            send_word(make_word(CMD_ADD, slot, window, rand_size(), rand_pa(),
                                RF_USR | RF_WR | RF_EX, '0));
            send_word(make_word(CMD_ADD, slot, window, rand_size(), rand_pa(), RF_RD, '0));
            repeat (6)
                send_fault(slot, window);
            send_word(make_word(CMD_CLEAR, slot, '0, '0, '0, '0, '0));
            send_word(make_word(CMD_ADD, slot, window, rand_size(), rand_pa(), RF_RD, '0));
        end
    endtask

    // back to back words with no idling on either side
    task automatic test_streaming();
        @(posedge clk);
        tx_gaps_on  = 1'b0;
        rx_stall_on = 1'b0;
        repeat (10)
            run_session();
        @(posedge clk);
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        @(posedge clk);
        tx_gaps_on   = 1'b0;
        hold_off_len = HOLD_CYCLES;
        repeat (4)
            run_session();
        tx_gaps_on = 1'b1;
    endtask

    // random sessions with some noise words, until the word budget is used
    task automatic test_random_sessions();
        while (words_sent < WORD_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                send_word(make_word(CMD_ADD + CMD_W'($urandom_range(0, 3)),
                                    CTXID_W'($urandom), rand_va(), rand_size(), rand_pa(),
                                    FLAG_W'($urandom), FCODE_W'($urandom)));
            else
                run_session();
        end
    endtask

    // sequence of tests
    initial
    begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_ADD;
        req_ch.context_req  = '0;
        req_ch.address      = '0;
        req_ch.region_size  = '0;
        req_ch.backing_base = '0;
        req_ch.region_flags = '0;
        req_ch.fault_code   = '0;
        for (int c = 0; c < N_CONTEXTS; c++)
            tbl_count[c] = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_region_extremes();
        test_table_full();
        test_streaming();
        test_backpressure();
        test_random_sessions();
        idle_channel();

        // drain, then watch for stray results
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("[region_fault_resolver] OK");
        else
            $display("[region_fault_resolver] ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/rfr_pkg.sv
rtl/rfr_req_if.sv
rtl/rfr_rsp_if.sv
rtl/region_fault_resolver.sv
tb/sv/tb_top.sv
